// ===== hdl/cir_pkg.sv =====
// ----------------------------------------------------------------------------
// cir_pkg
// Shared types and constants of the contact impulse resolver.
// ----------------------------------------------------------------------------
package cir_pkg;

    localparam int FIELD_W   = 60;
    localparam int MASS_W    = 16;
    localparam int BOUNCE_W  = 16;
    localparam int PEN_W     = 20;
    localparam int POS_SHIFT = 10;
    localparam int REST_FRAC = 15;
    localparam int Q_FRAC    = 20;
    localparam int Q_W       = 41;
    localparam logic [Q_W-1:0] Q_CLAMP = {1'b1, 40'b0};

    typedef struct packed {
        logic [FIELD_W-1:0]         contact_normal;
        logic signed [PEN_W-1:0]    penetration_depth;
        logic [FIELD_W-1:0]         velocity_one;
        logic [FIELD_W-1:0]         velocity_two;
        logic [FIELD_W-1:0]         accel_one;
        logic [FIELD_W-1:0]         accel_two;
        logic [MASS_W-1:0]          inv_mass_one;
        logic [MASS_W-1:0]          inv_mass_two;
        logic [BOUNCE_W-1:0]        bounce_one;
        logic [BOUNCE_W-1:0]        bounce_two;
        logic                       has_two;
    } t_in;

    typedef struct packed {
        logic [FIELD_W-1:0] delta_vel_one;
        logic [FIELD_W-1:0] delta_vel_two;
        logic [FIELD_W-1:0] move_one;
        logic [FIELD_W-1:0] move_two;
        logic               velocity_applied;
        logic               position_applied;
    } t_out;

    typedef struct packed {
        logic vel_ok;
        logic pos_ok;
        logic two;
    } t_flags;

endpackage

// ===== hdl/cir_front.sv =====
// ----------------------------------------------------------------------------
// cir_front
// Relative vectors, dot products, rebound and the two dividends, six stages.
// ----------------------------------------------------------------------------
module cir_front #(
    parameter int COMPONENT_WIDTH = 20
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_en,
    input  logic                                       i_valid,
    input  cir_pkg::t_in                               i_in,
    output logic                                       o_valid,
    output cir_pkg::t_flags                            o_flags,
    output logic [3*COMPONENT_WIDTH-1:0]               o_normal,
    output logic [cir_pkg::MASS_W:0]                   o_total,
    output logic [((2*COMPONENT_WIDTH+4 > 29) ? 2*COMPONENT_WIDTH+4 : 29)
                  + cir_pkg::MASS_W - 1:0]             o_vdiv,
    output logic [((2*COMPONENT_WIDTH+4 > 29) ? 2*COMPONENT_WIDTH+4 : 29)
                  + cir_pkg::MASS_W - 1:0]             o_pdiv,
    output logic [((2*COMPONENT_WIDTH+4 > 29) ? 2*COMPONENT_WIDTH+4 : 29)-1:0] o_dv,
    output logic [((2*COMPONENT_WIDTH+4 > 29) ? 2*COMPONENT_WIDTH+4 : 29)-1:0] o_pq
);
    import cir_pkg::*;

    localparam int CW = COMPONENT_WIDTH;
    localparam int VW = 3 * CW;
    localparam int QB = (2 * CW + 4 > 29) ? 2 * CW + 4 : 29;
    localparam int DW = QB + MASS_W;
    localparam int PW = 2 * CW + 1;
    localparam int SW = 2 * CW + 3;
    localparam int BW = SW + BOUNCE_W;

    logic [VW-1:0] n_vec, v1, v2, a1, a2;
    logic [MASS_W-1:0] m2_in;

    assign n_vec = VW'(i_in.contact_normal);
    assign v1    = VW'(i_in.velocity_one);
    assign v2    = VW'(i_in.velocity_two);
    assign a1    = VW'(i_in.accel_one);
    assign a2    = VW'(i_in.accel_two);
    assign m2_in = i_in.has_two ? i_in.inv_mass_two : '0;

    // stage 1
    logic                     r1_vld;
    logic signed [CW-1:0]     r1_n  [3];
    logic signed [CW:0]       r1_rv [3];
    logic signed [CW:0]       r1_ra [3];
    logic [MASS_W-1:0]        r1_m1;
    logic [MASS_W:0]          r1_total;
    logic [BOUNCE_W-1:0]      r1_b;
    logic signed [PEN_W-1:0]  r1_pen;
    logic                     r1_two;
    // stage 2
    logic                     r2_vld;
    logic signed [CW-1:0]     r2_n  [3];
    logic signed [PW-1:0]     r2_pv [3];
    logic signed [PW-1:0]     r2_pa [3];
    logic [MASS_W-1:0]        r2_m1;
    logic [MASS_W:0]          r2_total;
    logic [BOUNCE_W-1:0]      r2_b;
    logic signed [PEN_W-1:0]  r2_pen;
    logic                     r2_two;
    // stage 3
    logic                     r3_vld;
    logic [VW-1:0]            r3_n;
    logic signed [SW-1:0]     r3_sep;
    logic signed [SW-1:0]     r3_acc;
    logic [MASS_W-1:0]        r3_m1;
    logic [MASS_W:0]          r3_total;
    logic [BOUNCE_W-1:0]      r3_b;
    logic signed [PEN_W-1:0]  r3_pen;
    t_flags                   r3_fl;
    // stage 4
    logic                     r4_vld;
    logic [VW-1:0]            r4_n;
    logic [SW-1:0]            r4_nsep;
    logic [BW-1:0]            r4_bv;
    logic [BW-1:0]            r4_ab;
    logic [MASS_W-1:0]        r4_m1;
    logic [MASS_W:0]          r4_total;
    logic signed [PEN_W-1:0]  r4_pen;
    t_flags                   r4_fl;
    // stage 5
    logic                     r5_vld;
    logic [VW-1:0]            r5_n;
    logic [QB-1:0]            r5_dv;
    logic [QB-1:0]            r5_pq;
    logic [MASS_W-1:0]        r5_m1;
    logic [MASS_W:0]          r5_total;
    t_flags                   r5_fl;
    // stage 6
    logic                     r6_vld;
    logic [VW-1:0]            r6_n;
    logic [DW-1:0]            r6_vd;
    logic [DW-1:0]            r6_pd;
    logic [QB-1:0]            r6_dv;
    logic [QB-1:0]            r6_pq;
    logic [MASS_W:0]          r6_total;
    t_flags                   r6_fl;

    logic signed [SW-1:0]     n_sep, n_acc;
    logic [SW-1:0]            n_nsep, n_amag;
    logic [BW-1:0]            n_bvc;
    logic [BW+1:0]            n_dvs;
    logic [2*PEN_W+POS_SHIFT-PEN_W-1+PEN_W-PEN_W:0] n_pw;

    always_comb begin
        n_sep = SW'(r2_pv[0]) + SW'(r2_pv[1]) + SW'(r2_pv[2]);
        n_acc = SW'(r2_pa[0]) + SW'(r2_pa[1]) + SW'(r2_pa[2]);
        n_nsep = SW'(-r3_sep);
        n_amag = (r3_acc < 0) ? SW'(-r3_acc) : '0;
        n_bvc = (r4_bv > r4_ab) ? r4_bv - r4_ab : '0;
        n_dvs = (BW+2)'(n_bvc) + ((BW+2)'(r4_nsep) << REST_FRAC);
        n_pw  = {r4_pen, {POS_SHIFT{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_n[i]  <= $signed(n_vec[i*CW +: CW]);
                r1_rv[i] <= (CW+1)'($signed(v1[i*CW +: CW]))
                          - (i_in.has_two ? (CW+1)'($signed(v2[i*CW +: CW])) : '0);
                r1_ra[i] <= (CW+1)'($signed(a1[i*CW +: CW]))
                          - (i_in.has_two ? (CW+1)'($signed(a2[i*CW +: CW])) : '0);
                r2_n[i]  <= r1_n[i];
                r2_pv[i] <= PW'(r1_rv[i]) * PW'(r1_n[i]);
                r2_pa[i] <= PW'(r1_ra[i]) * PW'(r1_n[i]);
                r3_n[i*CW +: CW] <= r2_n[i];
            end
            r1_m1    <= i_in.inv_mass_one;
            r1_total <= (MASS_W+1)'(i_in.inv_mass_one) + (MASS_W+1)'(m2_in);
            r1_b     <= i_in.has_two
                      ? BOUNCE_W'(((BOUNCE_W+1)'(i_in.bounce_one)
                                  + (BOUNCE_W+1)'(i_in.bounce_two)) >> 1)
                      : i_in.bounce_one;
            r1_pen   <= i_in.penetration_depth;
            r1_two   <= i_in.has_two;

            r2_m1    <= r1_m1;
            r2_total <= r1_total;
            r2_b     <= r1_b;
            r2_pen   <= r1_pen;
            r2_two   <= r1_two;

            r3_sep   <= n_sep;
            r3_acc   <= n_acc;
            r3_m1    <= r2_m1;
            r3_total <= r2_total;
            r3_b     <= r2_b;
            r3_pen   <= r2_pen;
            r3_fl.vel_ok <= (n_sep <= 0) && (r2_total != '0);
            r3_fl.pos_ok <= (r2_pen > 0) && (r2_total != '0);
            r3_fl.two    <= r2_two;

            r4_n     <= r3_n;
            r4_nsep  <= n_nsep;
            r4_bv    <= BW'(n_nsep) * BW'(r3_b);
            r4_ab    <= BW'(n_amag) * BW'(r3_b);
            r4_m1    <= r3_m1;
            r4_total <= r3_total;
            r4_pen   <= r3_pen;
            r4_fl    <= r3_fl;

            r5_n     <= r4_n;
            r5_dv    <= QB'(n_dvs >> REST_FRAC);
            r5_pq    <= QB'(n_pw);
            r5_m1    <= r4_m1;
            r5_total <= r4_total;
            r5_fl    <= r4_fl;

            r6_n     <= r5_n;
            r6_vd    <= DW'(r5_dv) * DW'(r5_m1);
            r6_pd    <= DW'(r5_pq) * DW'(r5_m1);
            r6_dv    <= r5_dv;
            r6_pq    <= r5_pq;
            r6_total <= r5_total;
            r6_fl    <= r5_fl;
        end
    end

    assign o_valid  = r6_vld;
    assign o_flags  = r6_fl;
    assign o_normal = r6_n;
    assign o_total  = r6_total;
    assign o_vdiv   = r6_vd;
    assign o_pdiv   = r6_pd;
    assign o_dv     = r6_dv;
    assign o_pq     = r6_pq;

endmodule

// ===== hdl/cir_div.sv =====
// ----------------------------------------------------------------------------
// cir_div
// Pipelined restoring divider, one quotient bit per stage, two lanes.
// ----------------------------------------------------------------------------
module cir_div #(
    parameter int COMPONENT_WIDTH = 20
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_en,
    input  logic                                       i_valid,
    input  cir_pkg::t_flags                            i_flags,
    input  logic [3*COMPONENT_WIDTH-1:0]               i_normal,
    input  logic [cir_pkg::MASS_W:0]                   i_total,
    input  logic [((2*COMPONENT_WIDTH+4 > 29) ? 2*COMPONENT_WIDTH+4 : 29)
                  + cir_pkg::MASS_W - 1:0]             i_vdiv,
    input  logic [((2*COMPONENT_WIDTH+4 > 29) ? 2*COMPONENT_WIDTH+4 : 29)
                  + cir_pkg::MASS_W - 1:0]             i_pdiv,
    input  logic [((2*COMPONENT_WIDTH+4 > 29) ? 2*COMPONENT_WIDTH+4 : 29)-1:0] i_dv,
    input  logic [((2*COMPONENT_WIDTH+4 > 29) ? 2*COMPONENT_WIDTH+4 : 29)-1:0] i_pq,
    output logic                                       o_valid,
    output cir_pkg::t_flags                            o_flags,
    output logic [3*COMPONENT_WIDTH-1:0]               o_normal,
    output logic [((2*COMPONENT_WIDTH+4 > 29) ? 2*COMPONENT_WIDTH+4 : 29)-1:0] o_dv,
    output logic [((2*COMPONENT_WIDTH+4 > 29) ? 2*COMPONENT_WIDTH+4 : 29)-1:0] o_pq,
    output logic [((2*COMPONENT_WIDTH+4 > 29) ? 2*COMPONENT_WIDTH+4 : 29)-1:0] o_qv,
    output logic [((2*COMPONENT_WIDTH+4 > 29) ? 2*COMPONENT_WIDTH+4 : 29)-1:0] o_qp,
    output logic                                       o_rv_nz,
    output logic                                       o_rp_nz
);
    import cir_pkg::*;

    localparam int CW = COMPONENT_WIDTH;
    localparam int VW = 3 * CW;
    localparam int QB = (2 * CW + 4 > 29) ? 2 * CW + 4 : 29;
    localparam int DW = QB + MASS_W;

    typedef struct packed {
        logic [QB-1:0]     wv;
        logic [QB-1:0]     wp;
        logic [MASS_W:0]   rv;
        logic [MASS_W:0]   rp;
        logic [MASS_W:0]   tot;
        logic [QB-1:0]     dv;
        logic [QB-1:0]     pq;
        logic [VW-1:0]     nrm;
        t_flags            fl;
    } t_dst;

    function automatic t_dst div_step(input t_dst s);
        t_dst            o;
        logic [MASS_W+1:0] tv;
        logic [MASS_W+1:0] tp;
        o  = s;
        tv = {s.rv, s.wv[QB-1]};
        tp = {s.rp, s.wp[QB-1]};
        if (tv >= {1'b0, s.tot}) begin
            o.rv = (MASS_W+1)'(tv - {1'b0, s.tot});
            o.wv = {s.wv[QB-2:0], 1'b1};
        end else begin
            o.rv = tv[MASS_W:0];
            o.wv = {s.wv[QB-2:0], 1'b0};
        end
        if (tp >= {1'b0, s.tot}) begin
            o.rp = (MASS_W+1)'(tp - {1'b0, s.tot});
            o.wp = {s.wp[QB-2:0], 1'b1};
        end else begin
            o.rp = tp[MASS_W:0];
            o.wp = {s.wp[QB-2:0], 1'b0};
        end
        return o;
    endfunction

    t_dst in_st;
    t_dst r_st  [QB];
    logic r_vld [QB];

    always_comb begin
        in_st.wv  = i_vdiv[QB-1:0];
        in_st.wp  = i_pdiv[QB-1:0];
        in_st.rv  = (MASS_W+1)'(i_vdiv[DW-1:QB]);
        in_st.rp  = (MASS_W+1)'(i_pdiv[DW-1:QB]);
        in_st.tot = i_total;
        in_st.dv  = i_dv;
        in_st.pq  = i_pq;
        in_st.nrm = i_normal;
        in_st.fl  = i_flags;
    end

    for (genvar k = 0; k < QB; k++) begin : g_stage
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= i_valid;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_st[k] <= div_step(in_st);
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_st[k] <= div_step(r_st[k-1]);
                end
            end
        end
    end

    assign o_valid  = r_vld[QB-1];
    assign o_flags  = r_st[QB-1].fl;
    assign o_normal = r_st[QB-1].nrm;
    assign o_dv     = r_st[QB-1].dv;
    assign o_pq     = r_st[QB-1].pq;
    assign o_qv     = r_st[QB-1].wv;
    assign o_qp     = r_st[QB-1].wp;
    assign o_rv_nz  = (r_st[QB-1].rv != '0);
    assign o_rp_nz  = (r_st[QB-1].rp != '0);

endmodule

// ===== hdl/cir_back.sv =====
// ----------------------------------------------------------------------------
// cir_back
// Second body share, clamp, scale of the normal and saturating pack.
// ----------------------------------------------------------------------------
module cir_back #(
    parameter int COMPONENT_WIDTH = 20
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_en,
    input  logic                                       i_valid,
    input  cir_pkg::t_flags                            i_flags,
    input  logic [3*COMPONENT_WIDTH-1:0]               i_normal,
    input  logic [((2*COMPONENT_WIDTH+4 > 29) ? 2*COMPONENT_WIDTH+4 : 29)-1:0] i_dv,
    input  logic [((2*COMPONENT_WIDTH+4 > 29) ? 2*COMPONENT_WIDTH+4 : 29)-1:0] i_pq,
    input  logic [((2*COMPONENT_WIDTH+4 > 29) ? 2*COMPONENT_WIDTH+4 : 29)-1:0] i_qv,
    input  logic [((2*COMPONENT_WIDTH+4 > 29) ? 2*COMPONENT_WIDTH+4 : 29)-1:0] i_qp,
    input  logic                                       i_rv_nz,
    input  logic                                       i_rp_nz,
    output logic                                       o_valid,
    output cir_pkg::t_out                              o_out
);
    import cir_pkg::*;

    localparam int CW = COMPONENT_WIDTH;
    localparam int VW = 3 * CW;
    localparam int QB = (2 * CW + 4 > 29) ? 2 * CW + 4 : 29;
    localparam int QX = (QB > Q_W) ? QB : Q_W;
    localparam int MW = CW + Q_W;
    localparam int SMW = MW - Q_FRAC;
    localparam logic [SMW-1:0] CMAX = SMW'((64'd1 << (CW - 1)) - 64'd1);

    function automatic logic [Q_W-1:0] q_clamp(input logic [QB-1:0] q);
        logic [QX-1:0] x;
        x = QX'(q);
        return (x > QX'(Q_CLAMP)) ? Q_CLAMP : Q_W'(x);
    endfunction

    function automatic logic [CW-1:0] comp_sat(input logic neg, input logic [SMW-1:0] m);
        logic [SMW-1:0] c;
        c = m;
        if (!neg) begin
            if (c > CMAX) c = CMAX;
            return CW'(c);
        end
        if (c > CMAX + SMW'(1)) c = CMAX + SMW'(1);
        return CW'(-c);
    endfunction

    logic [QB-1:0] n_q2v, n_q2p;

    always_comb begin
        n_q2v = i_flags.two ? i_dv - i_qv - QB'(i_rv_nz) : '0;
        n_q2p = i_flags.two ? i_pq - i_qp - QB'(i_rp_nz) : '0;
    end

    logic               r1_vld;
    logic [Q_W-1:0]     r1_q   [4];
    logic [VW-1:0]      r1_n;
    t_flags             r1_fl;
    logic               r2_vld;
    logic [MW-1:0]      r2_p   [4][3];
    logic [2:0]         r2_sgn;
    t_flags             r2_fl;
    logic               r3_vld;
    t_out               r3_out;

    logic [CW-1:0]      n_mag  [3];
    logic [VW-1:0]      n_vec  [4];
    logic [SMW-1:0]     n_m;
    logic               n_neg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_mag[i] = r1_n[i*CW+CW-1] ? CW'(-r1_n[i*CW +: CW]) : r1_n[i*CW +: CW];
        end
        for (int j = 0; j < 4; j++) begin
            n_vec[j] = '0;
            for (int i = 0; i < 3; i++) begin
                n_m   = SMW'(r2_p[j][i] >> Q_FRAC);
                n_neg = (r2_sgn[i] ^ j[0]) && (n_m != '0);
                n_vec[j][i*CW +: CW] = comp_sat(n_neg, n_m);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_q[0] <= q_clamp(i_qv);
            r1_q[1] <= q_clamp(n_q2v);
            r1_q[2] <= q_clamp(i_qp);
            r1_q[3] <= q_clamp(n_q2p);
            r1_n    <= i_normal;
            r1_fl   <= i_flags;

            for (int j = 0; j < 4; j++) begin
                for (int i = 0; i < 3; i++) begin
                    r2_p[j][i] <= MW'(n_mag[i]) * MW'(r1_q[j]);
                end
            end
            for (int i = 0; i < 3; i++) begin
                r2_sgn[i] <= r1_n[i*CW+CW-1];
            end
            r2_fl <= r1_fl;

            r3_out.delta_vel_one <= r2_fl.vel_ok ? FIELD_W'(n_vec[0]) : '0;
            r3_out.delta_vel_two <= (r2_fl.vel_ok && r2_fl.two) ? FIELD_W'(n_vec[1]) : '0;
            r3_out.move_one      <= r2_fl.pos_ok ? FIELD_W'(n_vec[2]) : '0;
            r3_out.move_two      <= (r2_fl.pos_ok && r2_fl.two) ? FIELD_W'(n_vec[3]) : '0;
            r3_out.velocity_applied <= r2_fl.vel_ok;
            r3_out.position_applied <= r2_fl.pos_ok;
        end
    end

    assign o_valid = r3_vld;
    assign o_out   = r3_out;

endmodule

// ===== hdl/contact_impulse_resolver_top.sv =====
// ----------------------------------------------------------------------------
// contact_impulse_resolver_top
// Resolves one contact per transfer: velocity changes and position corrections.
// ----------------------------------------------------------------------------
// One contact enters per clock while o_stall is low. QB is the larger of
// 2*COMPONENT_WIDTH+4 and 29. The pipeline has six front stages for the dot
// products, rebound and dividends, one stage per quotient bit of the restoring
// divider (QB bits), and three back stages for the normal scaling and
// saturation. A stall on the output freezes every stage.
module contact_impulse_resolver_top #(
    parameter int COMPONENT_WIDTH = 20
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  cir_pkg::t_in   i_in,
    output logic           o_valid,
    input  logic           i_stall,
    output cir_pkg::t_out  o_out
);
    import cir_pkg::*;

    localparam int CW = COMPONENT_WIDTH;
    localparam int VW = 3 * CW;
    localparam int QB = (2 * CW + 4 > 29) ? 2 * CW + 4 : 29;
    localparam int DW = QB + MASS_W;

    logic            en;
    logic            f_vld, d_vld;
    t_flags          f_fl, d_fl;
    logic [VW-1:0]   f_n, d_n;
    logic [MASS_W:0] f_tot;
    logic [DW-1:0]   f_vd, f_pd;
    logic [QB-1:0]   f_dv, f_pq, d_dv, d_pq, d_qv, d_qp;
    logic            d_rv_nz, d_rp_nz;

    assign o_stall = o_valid && i_stall;
    assign en      = !o_stall;

    cir_front #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_in     (i_in),
        .o_valid  (f_vld),
        .o_flags  (f_fl),
        .o_normal (f_n),
        .o_total  (f_tot),
        .o_vdiv   (f_vd),
        .o_pdiv   (f_pd),
        .o_dv     (f_dv),
        .o_pq     (f_pq)
    );

    cir_div #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (f_vld),
        .i_flags  (f_fl),
        .i_normal (f_n),
        .i_total  (f_tot),
        .i_vdiv   (f_vd),
        .i_pdiv   (f_pd),
        .i_dv     (f_dv),
        .i_pq     (f_pq),
        .o_valid  (d_vld),
        .o_flags  (d_fl),
        .o_normal (d_n),
        .o_dv     (d_dv),
        .o_pq     (d_pq),
        .o_qv     (d_qv),
        .o_qp     (d_qp),
        .o_rv_nz  (d_rv_nz),
        .o_rp_nz  (d_rp_nz)
    );

    cir_back #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (d_vld),
        .i_flags  (d_fl),
        .i_normal (d_n),
        .i_dv     (d_dv),
        .i_pq     (d_pq),
        .i_qv     (d_qv),
        .i_qp     (d_qp),
        .i_rv_nz  (d_rv_nz),
        .i_rp_nz  (d_rp_nz),
        .o_valid  (o_valid),
        .o_out    (o_out)
    );

endmodule
